FILE: sv/alpha_trimmed_mean_window_assert.svh
// Assertion macros shared by the alpha-trimmed mean checker.
`ifndef ALPHA_TRIMMED_MEAN_WINDOW_ASSERT_SVH
`define ALPHA_TRIMMED_MEAN_WINDOW_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define ATMW_ASSERT_ALWAYS(lbl, clk_s, rst_s, expr, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (expr)) else $error(msg);

// Same-cycle implication.
`define ATMW_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ATMW_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/atmw_pkg.sv
// Types, constants and helper functions for the alpha-trimmed mean block.
package atmw_pkg;

    localparam int WIN_N            = 9;
    localparam int CENTER_IDX       = 4;
    localparam int PIX_W            = 8;
    localparam int TRIM_W           = 4;
    localparam int HALF_W           = TRIM_W - 1;
    localparam int SUM_W            = 12;
    localparam int RECIP_W          = 17;
    localparam int RECIP_SHIFT      = 16;
    localparam int PROD_W           = SUM_W + RECIP_W;
    localparam int FRONT_STAGES     = 3;
    localparam int PHASES_PER_STAGE = 3;
    localparam int BACK_STAGES      = 3;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef pix_t [WIN_N-1:0]  win_t;
    typedef logic [TRIM_W-1:0] trim_t;
    typedef logic [HALF_W-1:0] half_t;

    localparam trim_t TRIM_RESET = trim_t'(2);
    localparam trim_t TRIM_MAX   = trim_t'(8);

    // One window on its way from the sorter to the averaging stages
    typedef struct packed {
        win_t  px;
        pix_t  center;
        logic  pass;
        half_t half;
    } item_t;

    // One phase of odd-even transposition sort; nine phases order nine values
    function automatic win_t sort_phase(win_t w, logic odd_ph);
        win_t r;
        r = w;
        for (int i = 0; i < WIN_N - 1; i++)
        begin
            if ((i[0] == odd_ph) && (w[i] > w[i+1]))
            begin
                r[i]   = w[i+1];
                r[i+1] = w[i];
            end
        end
        return r;
    endfunction

    // Reciprocal of (9 - 2*half) scaled by 2^RECIP_SHIFT, rounded up.
    // Exact for every sum below 2^SUM_W.
    function automatic logic [RECIP_W-1:0] recip(half_t h);
        logic [RECIP_W-1:0] r;
        case (h)
            half_t'(0): r = RECIP_W'(7282);
            half_t'(1): r = RECIP_W'(9363);
            half_t'(2): r = RECIP_W'(13108);
            half_t'(3): r = RECIP_W'(21846);
            default:    r = RECIP_W'(65536);
        endcase
        return r;
    endfunction

endpackage

FILE: sv/atmw_if.sv
// Handshake channels of the alpha-trimmed mean block: window, result and trim setting.
interface atmw_win_if;
    import atmw_pkg::*;

    logic valid;
    logic ready;
    pix_t top_left;
    pix_t top_mid;
    pix_t top_right;
    pix_t mid_left;
    pix_t center;
    pix_t mid_right;
    pix_t bot_left;
    pix_t bot_mid;
    pix_t bot_right;

    modport source (
        output valid, top_left, top_mid, top_right, mid_left, center,
               mid_right, bot_left, bot_mid, bot_right,
        input  ready
    );
    modport sink (
        input  valid, top_left, top_mid, top_right, mid_left, center,
               mid_right, bot_left, bot_mid, bot_right,
        output ready
    );
endinterface

interface atmw_res_if;
    import atmw_pkg::*;

    logic valid;
    logic ready;
    pix_t mean_value;
    logic passed_through;

    modport source (output valid, mean_value, passed_through, input ready);
    modport sink (input valid, mean_value, passed_through, output ready);
endinterface

interface atmw_cfg_if;
    import atmw_pkg::*;

    logic  valid;
    logic  ready;
    trim_t trim_count;

    modport source (output valid, trim_count, input ready);
    modport sink (input valid, trim_count, output ready);
endinterface

FILE: sv/atmw_front.sv
// Front end: trim register, window classification and pipelined sorting network.
module atmw_front (
    input  logic              clk,
    input  logic              rst_n,
    atmw_win_if.sink          win,
    atmw_cfg_if.sink          cfg,
    output logic              out_valid,
    input  logic              out_ready,
    output atmw_pkg::item_t   out_item
);
    import atmw_pkg::*;

    trim_t                    trim_reg;
    item_t                    in_item;
    item_t                    stg_item_reg [FRONT_STAGES];
    logic                     stg_valid_reg [FRONT_STAGES];
    logic [FRONT_STAGES-1:0]  stg_adv;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_reg <= TRIM_RESET;
        end
        else if (cfg.valid)
        begin
            trim_reg <= cfg.trim_count;
        end
    end

    // Classify: an odd setting or one above eight passes the centre through
    always_comb
    begin
        in_item.px     = {win.bot_right, win.bot_mid, win.bot_left,
                          win.mid_right, win.center, win.mid_left,
                          win.top_right, win.top_mid, win.top_left};
        in_item.center = win.center;
        in_item.pass   = trim_reg[0] | (trim_reg > TRIM_MAX);
        in_item.half   = trim_reg[TRIM_W-1:1];
    end

    // A stage advances when it is empty or the stage after it advances
    always_comb
    begin
        stg_adv[FRONT_STAGES-1] = !stg_valid_reg[FRONT_STAGES-1] | out_ready;
        for (int s = FRONT_STAGES - 2; s >= 0; s--)
        begin
            stg_adv[s] = !stg_valid_reg[s] | stg_adv[s+1];
        end
    end

    assign win.ready = stg_adv[0];

    for (genvar s = 0; s < FRONT_STAGES; s++)
    begin : g_stage
        item_t stg_in;
        item_t stg_sorted;
        logic  stg_in_valid;

        if (s == 0)
        begin : g_first
            assign stg_in       = in_item;
            assign stg_in_valid = win.valid;
        end
        else
        begin : g_next
            assign stg_in       = stg_item_reg[s-1];
            assign stg_in_valid = stg_valid_reg[s-1];
        end

        always_comb
        begin
            stg_sorted = stg_in;
            for (int k = 0; k < PHASES_PER_STAGE; k++)
            begin
                stg_sorted.px = sort_phase(stg_sorted.px,
                                           ((s * PHASES_PER_STAGE + k) % 2) == 1);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stg_valid_reg[s] <= 1'b0;
            end
            else if (stg_adv[s])
            begin
                stg_valid_reg[s] <= stg_in_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stg_adv[s] && stg_in_valid)
            begin
                stg_item_reg[s] <= stg_sorted;
            end
        end
    end

    assign out_valid = stg_valid_reg[FRONT_STAGES-1];
    assign out_item  = stg_item_reg[FRONT_STAGES-1];

endmodule

FILE: sv/atmw_queue.sv
// Short queue decoupling the sorter from the averaging stages.
module atmw_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  atmw_pkg::item_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output atmw_pkg::item_t  out_item
);
    import atmw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: sv/atmw_back.sv
// Back end: sum of the kept values, reciprocal multiply and result register.
module atmw_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  atmw_pkg::item_t  in_item,
    atmw_res_if.source       res
);
    import atmw_pkg::*;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        half_t            half;
        pix_t             center;
        logic             pass;
    } sum_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        pix_t              center;
        logic              pass;
    } prod_t;

    sum_t   sum_reg;
    sum_t   sum_next;
    prod_t  prod_reg;
    prod_t  prod_next;
    pix_t   mean_reg;
    pix_t   mean_next;
    logic   pass_reg;
    logic   sum_valid_reg;
    logic   prod_valid_reg;
    logic   res_valid_reg;
    logic   adv_sum;
    logic   adv_prod;
    logic   adv_res;

    assign adv_res  = !res_valid_reg | res.ready;
    assign adv_prod = !prod_valid_reg | adv_res;
    assign adv_sum  = !sum_valid_reg | adv_prod;
    assign in_ready = adv_sum;

    // Keep the sorted values from index half up to, not including, nine minus half
    always_comb
    begin
        sum_next.sum    = '0;
        sum_next.half   = in_item.half;
        sum_next.center = in_item.center;
        sum_next.pass   = in_item.pass;
        for (int i = 0; i < WIN_N; i++)
        begin
            if ((i >= int'(in_item.half)) && (i < WIN_N - int'(in_item.half)))
            begin
                sum_next.sum = sum_next.sum + SUM_W'(in_item.px[i]);
            end
        end
    end

    always_comb
    begin
        prod_next.prod   = PROD_W'(sum_reg.sum) * PROD_W'(recip(sum_reg.half));
        prod_next.center = sum_reg.center;
        prod_next.pass   = sum_reg.pass;
    end

    assign mean_next = prod_reg.pass ? prod_reg.center
                                     : prod_reg.prod[RECIP_SHIFT +: PIX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv_sum)
            begin
                sum_valid_reg <= in_valid;
            end
            if (adv_prod)
            begin
                prod_valid_reg <= sum_valid_reg;
            end
            if (adv_res)
            begin
                res_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_sum && in_valid)
        begin
            sum_reg <= sum_next;
        end
        if (adv_prod && sum_valid_reg)
        begin
            prod_reg <= prod_next;
        end
        if (adv_res && prod_valid_reg)
        begin
            mean_reg <= mean_next;
            pass_reg <= prod_reg.pass;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.mean_value     = mean_reg;
    assign res.passed_through = pass_reg;

endmodule

FILE: sv/alpha_trimmed_mean_window.sv
// Alpha-trimmed mean of a 3x3 pixel window: top level.
//
// Channels: win carries one 3x3 window of 8-bit pixels per transaction, res
// returns the trimmed mean and a pass-through flag, cfg writes the 4-bit trim
// count (alpha). cfg is always ready; write it only while no window is in flight.
// Path: a window passes 3 sorting stages, the first loaded at the edge that
// takes the window, then 1 queue slot and 3 averaging stages, the last of
// them the registered result that drives res.valid.
// Throughput: one window per cycle while res.ready is high, set by the odd-even
// sorting pipeline and the one reciprocal multiplier in the back end.
// An odd trim count or one above eight passes the centre pixel through with
// passed_through set.
// Reset clears every pipeline stage and the queue and loads a trim count of 2.
// When the receiver stalls, the result holds in the output register, the
// back end and the queue fill, and win.ready falls only once every stage
// ahead of the stall is occupied.
module alpha_trimmed_mean_window #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    atmw_win_if.sink    win,
    atmw_cfg_if.sink    cfg,
    atmw_res_if.source  res
);
    import atmw_pkg::*;

    logic   front_valid;
    logic   front_ready;
    item_t  front_item;
    logic   back_valid;
    logic   back_ready;
    item_t  back_item;

    atmw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .win       (win),
        .cfg       (cfg),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    atmw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_item  (back_item)
    );

    atmw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (back_valid),
        .in_ready (back_ready),
        .in_item  (back_item),
        .res      (res)
    );

endmodule

FILE: sv/atmw_checker.sv
// Port-level checker for the alpha-trimmed mean block and its bind.
`include "alpha_trimmed_mean_window_assert.svh"

module atmw_port_checker #(
    parameter int CAPACITY = 8
) (
    input logic        clk,
    input logic        rst_n,
    input logic        win_valid,
    input logic        win_ready,
    input logic        cfg_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [7:0]  res_mean_value,
    input logic        res_passed_through
);
    localparam int OUT_W = $clog2(CAPACITY + 2);

    logic [OUT_W-1:0] outstanding_reg;
    logic [OUT_W-1:0] outstanding_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = win_valid & win_ready;
    assign out_acc = res_valid & res_ready;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (in_acc && !out_acc)
        begin
            outstanding_next = outstanding_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            outstanding_next = outstanding_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    `ATMW_ASSERT_ALWAYS(a_cfg_always_ready, clk, rst_n, cfg_ready, "cfg.ready dropped")

    `ATMW_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_mean_value) && $stable(res_passed_through), "stalled result changed")

    `ATMW_ASSERT_IMP(a_res_has_source, clk, rst_n, res_valid, outstanding_reg != '0, "result with no window in flight")

    `ATMW_ASSERT_ALWAYS(a_capacity, clk, rst_n, outstanding_reg <= OUT_W'(CAPACITY), "more windows in flight than stages")

endmodule

bind alpha_trimmed_mean_window atmw_port_checker #(
    .CAPACITY (atmw_pkg::FRONT_STAGES + atmw_pkg::BACK_STAGES + QUEUE_DEPTH)
) u_atmw_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .win_valid          (win.valid),
    .win_ready          (win.ready),
    .cfg_ready          (cfg.ready),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_mean_value     (res.mean_value),
    .res_passed_through (res.passed_through)
);
